// ===== design/tcpm_pkg.sv =====
// Shared types and constants for the two-channel phase meter.
`timescale 1ns / 1ps
package tcpm_pkg;

    localparam int ADC_BITS  = 14;
    localparam int CNT_BITS  = 16;
    localparam int DT_BITS   = 8;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 2;
    localparam int PH_BITS   = 16;
    localparam int CD_BITS   = 17;
    localparam int SCALE_BITS = 15;
    localparam int NUM_BITS  = SCALE_BITS + PH_BITS;
    localparam int DIV_CNT_BITS = $clog2(NUM_BITS);
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    localparam logic [SCALE_BITS-1:0] PHASE_SCALE = SCALE_BITS'(18000);
    localparam logic [NUM_BITS-1:0]   PHASE_SAT   = NUM_BITS'(36000);
    localparam logic signed [CD_BITS-1:0] CORR_BAND = CD_BITS'(160);
    localparam logic signed [CD_BITS-1:0] CORR_STEP = CD_BITS'(140);

    typedef enum logic [IDX_BITS-1:0] {
        CFG_LOW_THRESHOLD  = 2'd0,
        CFG_HIGH_THRESHOLD = 2'd1,
        CFG_PERIOD_OFFSET  = 2'd2,
        CFG_PHASE_OFFSET   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ADC_BITS-1:0]        low_threshold;
        logic [ADC_BITS-1:0]        high_threshold;
        logic signed [CFG_BITS-1:0] period_offset;
        logic signed [CFG_BITS-1:0] phase_offset;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_WAIT_REF_LOW   = 4'd0,
        ST_WAIT_REF_RISE  = 4'd1,
        ST_COUNT_PERIOD   = 4'd2,
        ST_WAIT_REF_PEAK  = 4'd3,
        ST_TRACK_REF      = 4'd4,
        ST_WAIT_TEST_PEAK = 4'd5,
        ST_TRACK_TEST     = 4'd6,
        ST_WAIT_BOTH_LOW  = 4'd7,
        ST_WAIT_FIRST     = 4'd8,
        ST_COUNT_PHASE    = 4'd9
    } t_step;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_MUL  = 3'd1,
        BK_DIV  = 3'd2,
        BK_FIN  = 3'd3,
        BK_OUT  = 3'd4
    } t_bstate;

    typedef struct packed {
        logic [CNT_BITS-1:0] period_ticks;
        logic [ADC_BITS-1:0] ref_peak;
        logic [ADC_BITS-1:0] test_peak;
        logic [PH_BITS-1:0]  phase_ticks;
        logic                test_first;
    } t_meas;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== design/two_channel_phase_meter.sv =====
// Top level of the two-channel phase meter: configuration registers, sequencer, queue, scaler.
`timescale 1ns / 1ps
// The meter takes one sample word (reference code, test code, elapsed ticks) every cycle while
// not stalled, and walks the measurement sequence: reference high time, reference peak, test peak,
// then the time from the first channel rising until both are high. The last word of a sequence
// queues one measurement, and the scaler turns it into one result word in steps: dequeue it,
// multiply by 18000, divide in the 31-bit restoring divider, saturate and correct, then the
// output register holds it until taken; the scaler takes no new measurement until that word
// is taken. A two-entry queue sits between the sequencer and the divider;
// the input stalls only while that queue is full. Write configuration only while idle.
module two_channel_phase_meter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tcpm_pkg::IDX_BITS-1:0]       i_cfg_idx,
    input  logic [tcpm_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tcpm_pkg::ADC_BITS-1:0]       i_ref_sample,
    input  logic [tcpm_pkg::ADC_BITS-1:0]       i_test_sample,
    input  logic [tcpm_pkg::DT_BITS-1:0]        i_elapsed_ticks,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tcpm_pkg::CNT_BITS-1:0]       o_period_ticks,
    output logic [tcpm_pkg::ADC_BITS-1:0]       o_ref_peak,
    output logic [tcpm_pkg::ADC_BITS-1:0]       o_test_peak,
    output logic [tcpm_pkg::PH_BITS-1:0]        o_phase_ticks,
    output logic signed [tcpm_pkg::CD_BITS-1:0] o_phase_centideg,
    output logic                                o_test_first
);
    import tcpm_pkg::*;

    t_cfg   r_cfg;
    logic   w_accept;
    logic   w_push;
    logic   w_pop;
    t_meas  w_front_meas;
    t_meas  w_q_meas;
    t_meas  w_out_meas;
    t_qstat w_qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold  <= ADC_BITS'(7);
            r_cfg.high_threshold <= ADC_BITS'(34);
            r_cfg.period_offset  <= CFG_BITS'(175);
            r_cfg.phase_offset   <= -CFG_BITS'(125);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LOW_THRESHOLD:  r_cfg.low_threshold  <= i_cfg_data[ADC_BITS-1:0];
                CFG_HIGH_THRESHOLD: r_cfg.high_threshold <= i_cfg_data[ADC_BITS-1:0];
                CFG_PERIOD_OFFSET:  r_cfg.period_offset  <= i_cfg_data;
                CFG_PHASE_OFFSET:   r_cfg.phase_offset   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = w_qstat.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    tcpm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_accept        (w_accept),
        .i_ref_sample    (i_ref_sample),
        .i_test_sample   (i_test_sample),
        .i_elapsed_ticks (i_elapsed_ticks),
        .o_push          (w_push),
        .o_meas          (w_front_meas)
    );

    tcpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_meas),
        .i_pop   (w_pop),
        .o_data  (w_q_meas),
        .o_stat  (w_qstat)
    );

    tcpm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_qstat.empty),
        .i_meas           (w_q_meas),
        .o_pop            (w_pop),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_meas           (w_out_meas),
        .o_phase_centideg (o_phase_centideg)
    );

    assign o_period_ticks = w_out_meas.period_ticks;
    assign o_ref_peak     = w_out_meas.ref_peak;
    assign o_test_peak    = w_out_meas.test_peak;
    assign o_phase_ticks  = w_out_meas.phase_ticks;
    assign o_test_first   = w_out_meas.test_first;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("measurement queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("measurement queue underflow");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_phase_centideg >= -CD_BITS'(36000)
                         && o_phase_centideg <= CD_BITS'(36000)))
        else $error("phase out of range");

    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_period_ticks == '0) |-> o_phase_centideg == '0)
        else $error("nonzero phase with zero period");

endmodule

// ===== design/tcpm_front.sv =====
// Measurement sequencer: classifies one sample word per cycle while not stalled and records each measurement.
`timescale 1ns / 1ps
module tcpm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcpm_pkg::t_cfg                i_cfg,
    input  logic                          i_accept,
    input  logic [tcpm_pkg::ADC_BITS-1:0] i_ref_sample,
    input  logic [tcpm_pkg::ADC_BITS-1:0] i_test_sample,
    input  logic [tcpm_pkg::DT_BITS-1:0]  i_elapsed_ticks,
    output logic                          o_push,
    output tcpm_pkg::t_meas               o_meas
);
    import tcpm_pkg::*;

    t_step               r_step, n_step;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [CNT_BITS-1:0] r_period, n_period;
    logic [ADC_BITS-1:0] r_ref_max, n_ref_max;
    logic [ADC_BITS-1:0] r_test_max, n_test_max;
    logic                r_sign, n_sign;

    logic r_low, r_high, t_low, t_high;
    logic [CNT_BITS-1:0] cnt_add;
    logic signed [CNT_BITS+1:0] phase_sum;
    logic [CNT_BITS+1:0] phase_abs;

    assign r_low   = i_ref_sample < i_cfg.low_threshold;
    assign r_high  = i_ref_sample > i_cfg.high_threshold;
    assign t_low   = i_test_sample < i_cfg.low_threshold;
    assign t_high  = i_test_sample > i_cfg.high_threshold;
    assign cnt_add = r_cnt + CNT_BITS'(i_elapsed_ticks);

    assign phase_sum = $signed({2'b00, cnt_add})
                     + $signed({{2{i_cfg.phase_offset[CFG_BITS-1]}}, i_cfg.phase_offset});
    assign phase_abs = phase_sum[CNT_BITS+1] ? -phase_sum : phase_sum;

    always_comb begin
        n_step = r_step;
        if (i_accept) begin
            case (r_step)
                ST_WAIT_REF_RISE:  if (r_high) n_step = ST_COUNT_PERIOD;
                ST_COUNT_PERIOD:   if (r_low) n_step = ST_WAIT_REF_PEAK;
                ST_WAIT_REF_PEAK:  if (r_high) n_step = ST_TRACK_REF;
                ST_TRACK_REF:      if (r_low) n_step = ST_WAIT_TEST_PEAK;
                ST_WAIT_TEST_PEAK: if (t_high) n_step = ST_TRACK_TEST;
                ST_TRACK_TEST:     if (t_low) n_step = ST_WAIT_BOTH_LOW;
                ST_WAIT_BOTH_LOW:  if (t_low && r_low) n_step = ST_WAIT_FIRST;
                ST_WAIT_FIRST:     if (t_high || r_high) n_step = ST_COUNT_PHASE;
                ST_COUNT_PHASE:    if (t_high && r_high) n_step = ST_WAIT_REF_LOW;
                default:           n_step = r_low ? ST_WAIT_REF_RISE : ST_WAIT_REF_LOW;
            endcase
        end
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_period   = r_period;
        n_ref_max  = r_ref_max;
        n_test_max = r_test_max;
        n_sign     = r_sign;
        o_push     = 1'b0;
        if (i_accept) begin
            case (r_step)
                ST_WAIT_REF_RISE: begin
                    if (r_high) n_cnt = '0;
                end
                ST_COUNT_PERIOD: begin
                    n_cnt = cnt_add;
                    if (r_low) n_period = cnt_add + CNT_BITS'(i_cfg.period_offset);
                end
                ST_WAIT_REF_PEAK: begin
                    if (r_high) n_ref_max = '0;
                end
                ST_TRACK_REF: begin
                    if (!r_low && i_ref_sample > r_ref_max) n_ref_max = i_ref_sample;
                end
                ST_WAIT_TEST_PEAK: begin
                    if (t_high) n_test_max = '0;
                end
                ST_TRACK_TEST: begin
                    if (!t_low && i_test_sample > r_test_max) n_test_max = i_test_sample;
                end
                ST_WAIT_FIRST: begin
                    if (t_high || r_high) begin
                        n_cnt  = '0;
                        n_sign = t_high;
                    end
                end
                ST_COUNT_PHASE: begin
                    n_cnt  = cnt_add;
                    o_push = t_high && r_high;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_meas.period_ticks = r_period;
    assign o_meas.ref_peak     = r_ref_max;
    assign o_meas.test_peak    = r_test_max;
    assign o_meas.phase_ticks  = phase_abs[PH_BITS-1:0];
    assign o_meas.test_first   = r_sign;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= ST_WAIT_REF_LOW;
            r_cnt      <= '0;
            r_period   <= '0;
            r_ref_max  <= '0;
            r_test_max <= '0;
            r_sign     <= 1'b0;
        end else begin
            r_step     <= n_step;
            r_cnt      <= n_cnt;
            r_period   <= n_period;
            r_ref_max  <= n_ref_max;
            r_test_max <= n_test_max;
            r_sign     <= n_sign;
        end
    end

endmodule

// ===== design/tcpm_queue.sv =====
// Short measurement queue between the sequencer and the phase divider.
`timescale 1ns / 1ps
module tcpm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tcpm_pkg::t_meas i_data,
    input  logic            i_pop,
    output tcpm_pkg::t_meas o_data,
    output tcpm_pkg::t_qstat o_stat
);
    import tcpm_pkg::*;

    t_meas                r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;

    assign o_stat.full  = r_count == (QPTR_BITS+1)'(QDEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/tcpm_back.sv =====
// Phase scaler: multiply, restoring divide, saturate and correct, then hold the result word.
`timescale 1ns / 1ps
module tcpm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  tcpm_pkg::t_meas                     i_meas,
    output logic                                o_pop,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output tcpm_pkg::t_meas                     o_meas,
    output logic signed [tcpm_pkg::CD_BITS-1:0] o_phase_centideg
);
    import tcpm_pkg::*;

    t_bstate                   r_state, n_state;
    t_meas                     r_meas;
    logic [NUM_BITS-1:0]       r_num;
    logic [CNT_BITS-1:0]       r_rem;
    logic [DIV_CNT_BITS-1:0]   r_div_cnt;
    logic signed [CD_BITS-1:0] r_phase_cd;

    logic [CNT_BITS:0]         rem_shift;
    logic                      rem_ge;
    logic [CNT_BITS:0]         rem_sub;
    logic [PH_BITS-1:0]        sat_m;
    logic signed [CD_BITS-1:0] signed_m;
    logic signed [CD_BITS-1:0] fin_cd;

    assign rem_shift = {r_rem, r_num[NUM_BITS-1]};
    assign rem_ge    = rem_shift >= {1'b0, r_meas.period_ticks};
    assign rem_sub   = rem_shift - {1'b0, r_meas.period_ticks};

    always_comb begin
        sat_m    = (r_num > PHASE_SAT) ? PHASE_SAT[PH_BITS-1:0] : r_num[PH_BITS-1:0];
        signed_m = r_meas.test_first ? $signed({1'b0, sat_m}) : -$signed({1'b0, sat_m});
        fin_cd   = signed_m;
        if (signed_m > -CORR_BAND && signed_m < CORR_BAND) fin_cd = signed_m - CORR_STEP;
        if (r_meas.period_ticks == '0) fin_cd = '0;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (!i_q_empty) n_state = BK_MUL;
            BK_MUL:  n_state = BK_DIV;
            BK_DIV:  if (r_div_cnt == '0) n_state = BK_FIN;
            BK_FIN:  n_state = BK_OUT;
            BK_OUT:  if (!i_out_stall) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = (r_state == BK_IDLE) && !i_q_empty;
        o_out_valid = r_state == BK_OUT;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) r_meas <= i_meas;
            end
            BK_MUL: begin
                r_num     <= NUM_BITS'(PHASE_SCALE * r_meas.phase_ticks);
                r_rem     <= '0;
                r_div_cnt <= DIV_CNT_BITS'(NUM_BITS - 1);
            end
            BK_DIV: begin
                r_rem     <= rem_ge ? rem_sub[CNT_BITS-1:0] : rem_shift[CNT_BITS-1:0];
                r_num     <= {r_num[NUM_BITS-2:0], rem_ge};
                r_div_cnt <= r_div_cnt - 1'b1;
            end
            BK_FIN: begin
                r_phase_cd <= fin_cd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_meas           = r_meas;
    assign o_phase_centideg = r_phase_cd;

endmodule

// ===== verif/two_channel_phase_meter_tb.sv =====
// Self-checking testbench for the two-channel phase meter: directed and guided random words.
`timescale 1ns / 1ps
module two_channel_phase_meter_tb;
    import tcpm_pkg::*;

    localparam int CODE_MAX     = (1 << ADC_BITS) - 1;
    localparam int SCALE        = 18000;
    localparam int SAT_LIMIT    = 36000;
    localparam int BAND         = 160;
    localparam int BAND_STEP    = 140;
    localparam int DRAIN_WAIT   = 64;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_WORDS  = 180;
    localparam int DWELL_PCT    = 60;
    localparam int NOISE_PCT    = 8;
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef struct packed {
        logic [CNT_BITS-1:0]       period_ticks;
        logic [ADC_BITS-1:0]       ref_peak;
        logic [ADC_BITS-1:0]       test_peak;
        logic [PH_BITS-1:0]        phase_ticks;
        logic signed [CD_BITS-1:0] phase_centideg;
        logic                      test_first;
    } meas_word_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [IDX_BITS-1:0]       i_cfg_idx = CFG_LOW_THRESHOLD;
    logic [CFG_BITS-1:0]       i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [ADC_BITS-1:0]       i_ref_sample = '0;
    logic [ADC_BITS-1:0]       i_test_sample = '0;
    logic [DT_BITS-1:0]        i_elapsed_ticks = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [CNT_BITS-1:0]       o_period_ticks;
    logic [ADC_BITS-1:0]       o_ref_peak;
    logic [ADC_BITS-1:0]       o_test_peak;
    logic [PH_BITS-1:0]        o_phase_ticks;
    logic signed [CD_BITS-1:0] o_phase_centideg;
    logic                      o_test_first;

    logic [ADC_BITS-1:0] low_thr;
    logic [ADC_BITS-1:0] high_thr;
    shortint             period_off;
    shortint             phase_off;

    t_step               meter_step;
    logic [CNT_BITS-1:0] tick_cnt;
    logic [CNT_BITS-1:0] period_hold;
    logic [ADC_BITS-1:0] ref_max;
    logic [ADC_BITS-1:0] test_max;
    logic                sign_hold;

    meas_word_t pending_meas[$];
    int         mismatches = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;

    two_channel_phase_meter i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_ref_sample     (i_ref_sample),
        .i_test_sample    (i_test_sample),
        .i_elapsed_ticks  (i_elapsed_ticks),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_period_ticks   (o_period_ticks),
        .o_ref_peak       (o_ref_peak),
        .o_test_peak      (o_test_peak),
        .o_phase_ticks    (o_phase_ticks),
        .o_phase_centideg (o_phase_centideg),
        .o_test_first     (o_test_first)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    task automatic reset_meter();
        low_thr     = ADC_BITS'(7);
        high_thr    = ADC_BITS'(34);
        period_off  = 175;
        phase_off   = -125;
        meter_step  = ST_WAIT_REF_LOW;
        tick_cnt    = '0;
        period_hold = '0;
        ref_max     = '0;
        test_max    = '0;
        sign_hold   = 1'b0;
    endtask

    task automatic advance_meter(input logic [ADC_BITS-1:0] r, input logic [ADC_BITS-1:0] t,
                                 input logic [DT_BITS-1:0] dt);
        bit         r_low;
        bit         r_high;
        bit         t_low;
        bit         t_high;
        int         p;
        int         c;
        longint     m;
        meas_word_t w;
        r_low  = r < low_thr;
        r_high = r > high_thr;
        t_low  = t < low_thr;
        t_high = t > high_thr;
        case (meter_step)
            ST_WAIT_REF_RISE: begin
                if (r_high) begin
                    tick_cnt   = '0;
                    meter_step = ST_COUNT_PERIOD;
                end
            end
            ST_COUNT_PERIOD: begin
                tick_cnt = tick_cnt + CNT_BITS'(dt);
                if (r_low) begin
                    period_hold = CNT_BITS'(int'(tick_cnt) + int'(period_off));
                    meter_step  = ST_WAIT_REF_PEAK;
                end
            end
            ST_WAIT_REF_PEAK: begin
                if (r_high) begin
                    ref_max    = '0;
                    meter_step = ST_TRACK_REF;
                end
            end
            ST_TRACK_REF: begin
                if (r_low) meter_step = ST_WAIT_TEST_PEAK;
                else if (r > ref_max) ref_max = r;
            end
            ST_WAIT_TEST_PEAK: begin
                if (t_high) begin
                    test_max   = '0;
                    meter_step = ST_TRACK_TEST;
                end
            end
            ST_TRACK_TEST: begin
                if (t_low) meter_step = ST_WAIT_BOTH_LOW;
                else if (t > test_max) test_max = t;
            end
            ST_WAIT_BOTH_LOW: begin
                if (t_low && r_low) meter_step = ST_WAIT_FIRST;
            end
            ST_WAIT_FIRST: begin
                if (t_high || r_high) begin
                    tick_cnt   = '0;
                    sign_hold  = t_high;
                    meter_step = ST_COUNT_PHASE;
                end
            end
            ST_COUNT_PHASE: begin
                tick_cnt = tick_cnt + CNT_BITS'(dt);
                if (t_high && r_high) begin
                    p = int'(tick_cnt) + int'(phase_off);
                    w.phase_ticks = PH_BITS'(p < 0 ? -p : p);
                    c = 0;
                    if (period_hold != 0) begin
                        m = (longint'(SCALE) * longint'(w.phase_ticks)) / longint'(period_hold);
                        if (m > SAT_LIMIT) m = SAT_LIMIT;
                        c = sign_hold ? int'(m) : -int'(m);
                        if (c > -BAND && c < BAND) c = c - BAND_STEP;
                    end
                    w.period_ticks   = period_hold;
                    w.ref_peak       = ref_max;
                    w.test_peak      = test_max;
                    w.phase_centideg = CD_BITS'(c);
                    w.test_first     = sign_hold;
                    pending_meas.push_back(w);
                    meter_step = ST_WAIT_REF_LOW;
                end
            end
            default: meter_step = r_low ? ST_WAIT_REF_RISE : ST_WAIT_REF_LOW;
        endcase
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : meas_check
        meas_word_t w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_meas.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t unexpected result word: period_ticks %0d phase_ticks %0d",
                             $time, o_period_ticks, o_phase_ticks);
            end else begin
                w = pending_meas.pop_front();
                check_field("period_ticks", w.period_ticks, o_period_ticks);
                check_field("ref_peak", w.ref_peak, o_ref_peak);
                check_field("test_peak", w.test_peak, o_test_peak);
                check_field("phase_ticks", w.phase_ticks, o_phase_ticks);
                check_field("phase_centideg", w.phase_centideg, o_phase_centideg);
                check_field("test_first", w.test_first, o_test_first);
            end
        end
    end

    function automatic logic [ADC_BITS-1:0] rand_code();
        return ADC_BITS'($urandom);
    endfunction

    function automatic logic [ADC_BITS-1:0] code_below(input int thr);
        return (thr <= 0) ? rand_code() : ADC_BITS'($urandom_range(thr - 1, 0));
    endfunction

    function automatic logic [ADC_BITS-1:0] code_above(input int thr);
        return (thr >= CODE_MAX) ? rand_code() : ADC_BITS'($urandom_range(CODE_MAX, thr + 1));
    endfunction

    function automatic logic [ADC_BITS-1:0] code_at_least(input int thr);
        if ($urandom_range(7) == 0) return ADC_BITS'(CODE_MAX);
        return ADC_BITS'($urandom_range(CODE_MAX, thr));
    endfunction

    function automatic logic [ADC_BITS-1:0] code_at_most(input int thr);
        return ADC_BITS'($urandom_range(thr, 0));
    endfunction

    function automatic logic [DT_BITS-1:0] rand_ticks();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return DT_BITS'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [ADC_BITS-1:0] r, input logic [ADC_BITS-1:0] t,
                             input logic [DT_BITS-1:0] dt);
        @(negedge i_clk);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid      <= 1'b0;
            i_ref_sample    <= rand_code();
            i_test_sample   <= rand_code();
            i_elapsed_ticks <= DT_BITS'($urandom);
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_ref_sample    <= r;
        i_test_sample   <= t;
        i_elapsed_ticks <= dt;
        do @(posedge i_clk); while (o_in_stall);
        advance_meter(r, t, dt);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_meas.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            CFG_LOW_THRESHOLD:  low_thr    = v[ADC_BITS-1:0];
            CFG_HIGH_THRESHOLD: high_thr   = v[ADC_BITS-1:0];
            CFG_PERIOD_OFFSET:  period_off = shortint'(v);
            CFG_PHASE_OFFSET:   phase_off  = shortint'(v);
            default: ;
        endcase
    endtask

    task automatic load_config(input int lo, input int hi, input int poff, input int phoff);
        write_reg(CFG_LOW_THRESHOLD, CFG_BITS'(lo));
        write_reg(CFG_HIGH_THRESHOLD, CFG_BITS'(hi));
        write_reg(CFG_PERIOD_OFFSET, CFG_BITS'(poff));
        write_reg(CFG_PHASE_OFFSET, CFG_BITS'(phoff));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One full sequence from the idle step; counts are period_len*dt and phase_len*dt.
    task automatic send_measurement(input int period_len, input int phase_len,
                                    input logic [DT_BITS-1:0] dt, input bit test_leads);
        int lo;
        int hi;
        int k;
        lo = low_thr;
        hi = high_thr;
        send_word('0, '0, '0);
        send_word(ADC_BITS'(CODE_MAX), rand_code(), rand_ticks());
        for (k = 1; k < period_len; k++) send_word(code_at_least(lo), rand_code(), dt);
        send_word(code_below(lo), rand_code(), dt);
        send_word(code_above(hi), rand_code(), rand_ticks());
        send_word(ADC_BITS'(CODE_MAX), rand_code(), rand_ticks());
        send_word(code_below(lo), rand_code(), rand_ticks());
        send_word(rand_code(), code_above(hi), rand_ticks());
        send_word(rand_code(), ADC_BITS'(CODE_MAX), rand_ticks());
        send_word(rand_code(), code_below(lo), rand_ticks());
        send_word('0, '0, rand_ticks());
        for (k = 0; k < phase_len; k++) begin
            if (test_leads)
                send_word(code_at_most(hi), code_above(hi), (k == 0) ? rand_ticks() : dt);
            else
                send_word(code_above(hi), code_at_most(hi), (k == 0) ? rand_ticks() : dt);
        end
        send_word(code_above(hi), code_above(hi), dt);
    endtask

    task automatic send_guided_word();
        logic [ADC_BITS-1:0] r;
        logic [ADC_BITS-1:0] t;
        bit                  adv;
        int                  lo;
        int                  hi;
        lo  = low_thr;
        hi  = high_thr;
        r   = rand_code();
        t   = rand_code();
        adv = $urandom_range(99) >= DWELL_PCT;
        if ($urandom_range(99) >= NOISE_PCT) begin
            case (meter_step)
                ST_WAIT_REF_LOW, ST_COUNT_PERIOD, ST_TRACK_REF:
                    r = adv ? code_below(lo) : code_at_least(lo);
                ST_WAIT_REF_RISE, ST_WAIT_REF_PEAK:
                    r = adv ? code_above(hi) : code_at_most(hi);
                ST_WAIT_TEST_PEAK:
                    t = adv ? code_above(hi) : code_at_most(hi);
                ST_TRACK_TEST:
                    t = adv ? code_below(lo) : code_at_least(lo);
                ST_WAIT_BOTH_LOW: begin
                    r = code_below(lo);
                    t = code_below(lo);
                    if (!adv) begin
                        if ($urandom_range(1)) r = code_at_least(lo);
                        else t = code_at_least(lo);
                    end
                end
                ST_WAIT_FIRST: begin
                    r = code_at_most(hi);
                    t = code_at_most(hi);
                    if (adv) begin
                        case ($urandom_range(2))
                            0:       r = code_above(hi);
                            1:       t = code_above(hi);
                            default: begin
                                r = code_above(hi);
                                t = code_above(hi);
                            end
                        endcase
                    end
                end
                ST_COUNT_PHASE: begin
                    r = code_above(hi);
                    t = code_above(hi);
                    if (!adv) begin
                        if ($urandom_range(1)) r = code_at_most(hi);
                        else t = code_at_most(hi);
                    end
                end
                default: ;
            endcase
        end
        send_word(r, t, rand_ticks());
    endtask

    task automatic run_random_phase(input int gap, input int stall, input int lo, input int hi,
                                    input int poff, input int phoff);
        int n;
        load_config(lo, hi, poff, phoff);
        gap_pct   = gap;
        stall_pct = stall;
        for (n = 0; n < PHASE_WORDS; n++) send_guided_word();
        drain();
    endtask

    task automatic test_reset_defaults();
        send_measurement(1, 1, '1, 1'b0);
        drain();
    endtask

    task automatic test_zero_period();
        load_config(7, 34, -200, -125);
        send_measurement(1, 3, DT_BITS'(200), 1'b1);
        drain();
    endtask

    // Hit both edges of the correction band with a period of exactly SCALE ticks.
    task automatic test_correction_band();
        load_config(7, 34, SCALE - 100, (BAND - 1) - 100);
        send_measurement(1, 1, DT_BITS'(100), 1'b1);
        drain();
        load_config(7, 34, SCALE - 100, -BAND - 100);
        send_measurement(1, 1, DT_BITS'(100), 1'b0);
        drain();
    endtask

    // No code is below zero, so the sequence must hold in its first step.
    task automatic test_dead_thresholds();
        int k;
        load_config(0, CODE_MAX, 0, 0);
        send_word('0, '0, '0);
        send_word(ADC_BITS'(CODE_MAX), ADC_BITS'(CODE_MAX), '1);
        for (k = 0; k < 8; k++) send_word(rand_code(), rand_code(), rand_ticks());
        drain();
    endtask

    task automatic test_counter_wrap();
        load_config(100, 9000, 300, -300);
        send_measurement(262, 3, '1, 1'b1);
        drain();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, $urandom_range(1, 3000), 0, 0, 0);
        run_random_phase(0, 0, $urandom_range(1, 3000), $urandom_range(3000, 7000),
                         int'($signed(CFG_BITS'($urandom))), int'($signed(CFG_BITS'($urandom))));
        run_random_phase(73, 0, CODE_MAX, 0, -32768, 32767);
        run_random_phase(0, 73, 1, CODE_MAX - 1, 32767, -32768);
        run_random_phase(26, 26, $urandom_range(1, CODE_MAX), $urandom_range(0, CODE_MAX - 1),
                         0, 0);
    endtask

    initial begin
        reset_meter();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_zero_period();
        test_correction_band();
        test_dead_thresholds();
        test_counter_wrap();
        test_random_traffic();
        if (mismatches == 0 && pending_meas.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
